// ===== rtl/bitmap_handle_allocator_unit_defines.svh =====
// Assertion macros shared by the checker of the bitmap handle allocator.
// No dependencies; included by the checker file only.
`ifndef BITMAP_HANDLE_ALLOCATOR_UNIT_DEFINES_SVH
`define BITMAP_HANDLE_ALLOCATOR_UNIT_DEFINES_SVH

// Clocked assertion that is switched off while reset is active.
`define BHAU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define BHAU_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/bhau_pkg.sv =====
// Types and constants of the bitmap handle allocator.
// No dependencies; used by every RTL file of the block.
package bhau_pkg;

    localparam int WORD_W   = 64;
    localparam int BIT_W    = 6;
    localparam int HANDLE_W = 10;
    localparam int TDATA_W  = 16;

    // Operation codes carried on the input tuser.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef logic [WORD_W-1:0] map_word_t;

    // Result of the lowest-clear-bit unit.
    typedef struct packed {
        logic             full;
        logic [BIT_W-1:0] bit_idx;
        map_word_t        onehot;
    } lcb_res_t;

endpackage

// ===== rtl/bhau_map_mem.sv =====
// Used-bit map storage: one write and one registered read port per cycle.
// Words never written since reset read as zero through per-word valid bits.
// Depends on bhau_pkg.
module bhau_map_mem #(
    parameter int MAP_WORDS = 16,
    parameter int AW        = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [AW-1:0]       wr_addr,
    input  bhau_pkg::map_word_t wr_data,
    input  logic [AW-1:0]       rd_addr,
    output bhau_pkg::map_word_t rd_data
);

    bhau_pkg::map_word_t mem [MAP_WORDS];
    logic [MAP_WORDS-1:0] valid_reg;
    bhau_pkg::map_word_t  rd_data_reg;

    // Valid bits make the whole map read as free right after reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Storage array with registered read data.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/bhau_lcb.sv =====
// Lowest-clear-bit unit shared by every step of the allocation scan.
// Depends on bhau_pkg.
module bhau_lcb (
    input  bhau_pkg::map_word_t word,
    output bhau_pkg::lcb_res_t  res
);

    bhau_pkg::map_word_t onehot;
    logic [bhau_pkg::BIT_W-1:0] idx;

    // Adding one carries through the trailing ones and lands on the lowest zero.
    assign onehot = ~word & (word + bhau_pkg::map_word_t'(1));

    // Encode the one-hot position with an OR over independent bits.
    always_comb
    begin
        idx = '0;
        for (int i = 0; i < bhau_pkg::WORD_W; i++)
        begin
            if (onehot[i])
            begin
                idx = idx | bhau_pkg::BIT_W'(i);
            end
        end
    end

    assign res.full    = &word;
    assign res.bit_idx = idx;
    assign res.onehot  = onehot;

endmodule

// ===== rtl/bitmap_handle_allocator_unit.sv =====
// Top level of the bitmap handle allocator: sequencer, hint and result register.
// Depends on bhau_pkg, bhau_map_mem and bhau_lcb.
//
// Usage:
//   The input channel takes one word per request: tuser is the operation
//   (0 allocate, 1 free) and tdata carries the handle to free. The output
//   channel carries one word per allocate: tdata is the handle, tuser is the
//   full flag (handle reads 0 then). A free gives no output word.
//   Timing: after a word is accepted the input is not ready until the
//   request is done. A free reads the map word, then writes it back.
//   An allocate reads one map word per cycle starting at the hint word while
//   the output register is free, looking at most at MAP_WORDS words; the
//   result is shown the cycle after the scan ends. The map memory read port
//   sets this pace.
//   Reset clears the whole map (every handle free) and sets the hint to word 0
//   at once; no sweep is needed.
//   A stalled receiver holds the pending result; the next request may still be
//   accepted, and an allocate then waits at its first map word, before any
//   scanning, until the output register is free.
module bitmap_handle_allocator_unit #(
    parameter int MAP_WORDS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [9:0] free_handle, [15:10] zero
    input  logic [bhau_pkg::TDATA_W-1:0]   s_axis_tdata,
    // [0] opcode
    input  logic                           s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [9:0] handle, [15:10] zero
    output logic [bhau_pkg::TDATA_W-1:0]   m_axis_tdata,
    // [0] full_res
    output logic                           m_axis_tuser
);

    localparam int AW  = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int WIW = (AW > 4) ? AW : 4;
    localparam logic [AW-1:0] LAST_WORD = AW'(MAP_WORDS - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_FREE = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [AW-1:0] hint_reg, hint_next;
    logic [AW-1:0] cur_reg, cur_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic [bhau_pkg::BIT_W-1:0] fbit_reg, fbit_next;
    logic          frange_reg, frange_next;
    logic          out_valid_reg, out_valid_next;
    logic [bhau_pkg::HANDLE_W-1:0] out_handle_reg, out_handle_next;
    logic          out_full_reg, out_full_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr, rd_addr, cur_wrap;
    bhau_pkg::map_word_t wr_data, word;
    bhau_pkg::lcb_res_t  lcb;
    logic          in_accept, out_free;
    logic [3:0]    in_word;
    logic [WIW-1:0] in_word_ext, cur_ext;

    bhau_map_mem #(
        .MAP_WORDS (MAP_WORDS),
        .AW        (AW)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (word)
    );

    bhau_lcb u_lcb (
        .word (word),
        .res  (lcb)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign in_word       = s_axis_tdata[bhau_pkg::HANDLE_W-1:bhau_pkg::BIT_W];
    assign in_word_ext   = WIW'(in_word);
    assign cur_ext       = WIW'(cur_reg);
    assign cur_wrap      = (cur_reg == LAST_WORD) ? '0 : cur_reg + AW'(1);

    // Sequencer: one map word per cycle through the shared bit unit while the output register is free.
    always_comb
    begin
        state_next      = state_reg;
        hint_next       = hint_reg;
        cur_next        = cur_reg;
        cnt_next        = cnt_reg;
        fbit_next       = fbit_reg;
        frange_next     = frange_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_handle_next = out_handle_reg;
        out_full_next   = out_full_reg;
        rd_addr         = cur_reg;
        wr_en           = 1'b0;
        wr_addr         = cur_reg;
        wr_data         = word;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (s_axis_tuser == bhau_pkg::OP_ALLOC)
                    begin
                        rd_addr    = hint_reg;
                        cur_next   = hint_reg;
                        cnt_next   = '0;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        rd_addr     = in_word_ext[AW-1:0];
                        cur_next    = in_word_ext[AW-1:0];
                        fbit_next   = s_axis_tdata[bhau_pkg::BIT_W-1:0];
                        frange_next = (32'(in_word) < 32'(MAP_WORDS));
                        state_next  = ST_FREE;
                    end
                end
            end
            ST_SCAN:
            begin
                if (out_free)
                begin
                    if (!lcb.full)
                    begin
                        wr_en           = 1'b1;
                        wr_data         = word | lcb.onehot;
                        hint_next       = cur_reg;
                        out_valid_next  = 1'b1;
                        out_handle_next = {cur_ext[3:0], lcb.bit_idx};
                        out_full_next   = 1'b0;
                        state_next      = ST_IDLE;
                    end
                    else if (cnt_reg == LAST_WORD)
                    begin
                        out_valid_next  = 1'b1;
                        out_handle_next = '0;
                        out_full_next   = 1'b1;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        rd_addr  = cur_wrap;
                        cur_next = cur_wrap;
                        cnt_next = cnt_reg + AW'(1);
                    end
                end
            end
            ST_FREE:
            begin
                wr_en      = frange_reg;
                wr_data    = word & ~(bhau_pkg::map_word_t'(1) << fbit_reg);
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            hint_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            hint_reg      <= hint_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working and result payload registers.
    always_ff @(posedge clk)
    begin
        cur_reg        <= cur_next;
        cnt_reg        <= cnt_next;
        fbit_reg       <= fbit_next;
        frange_reg     <= frange_next;
        out_handle_reg <= out_handle_next;
        out_full_reg   <= out_full_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = bhau_pkg::TDATA_W'(out_handle_reg);
    assign m_axis_tuser  = out_full_reg;

endmodule

// ===== rtl/bhau_checker.sv =====
// Port-level checker of the bitmap handle allocator, bound to the top level.
// Depends on bhau_pkg and bitmap_handle_allocator_unit_defines.svh.
`include "bitmap_handle_allocator_unit_defines.svh"

module bhau_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_axis_tvalid,
    input logic                         s_axis_tready,
    input logic [bhau_pkg::TDATA_W-1:0] s_axis_tdata,
    input logic                         s_axis_tuser,
    input logic                         m_axis_tvalid,
    input logic                         m_axis_tready,
    input logic [bhau_pkg::TDATA_W-1:0] m_axis_tdata,
    input logic                         m_axis_tuser
);

    logic                         in_word;
    logic                         in_stall;
    logic                         in_free;
    logic                         out_stall;
    logic                         out_full;
    logic [bhau_pkg::TDATA_W:0]   in_payload;

    assign in_word    = s_axis_tvalid && s_axis_tready;
    assign in_stall   = s_axis_tvalid && !s_axis_tready;
    assign in_free    = in_word && (s_axis_tuser == bhau_pkg::OP_FREE);
    assign out_stall  = m_axis_tvalid && !m_axis_tready;
    assign out_full   = m_axis_tvalid && m_axis_tuser;
    assign in_payload = {s_axis_tuser, s_axis_tdata};

    // A pending output word stays until it is taken.
    `BHAU_ASSERT(a_out_hold, out_stall |=> m_axis_tvalid, "output word dropped")

    // A waiting input word is held steady until it is accepted.
    `BHAU_ASSERT(a_in_hold, in_stall |=> s_axis_tvalid && $stable(in_payload), "input word changed")

    // Every accepted request leaves the input not ready in the next cycle.
    `BHAU_ASSERT(a_busy_after_accept, in_word |=> !s_axis_tready, "ready right after accept")

    // A failed allocation always reports handle zero.
    `BHAU_ASSERT(a_full_handle_zero, out_full |-> m_axis_tdata == '0, "full with nonzero handle")

    // A free request never starts an output word in the next cycle.
    `BHAU_ASSERT(a_free_no_result, in_free |=> !$rose(m_axis_tvalid), "free produced a result")

    // Output valid is low in the cycle after a reset cycle.
    `BHAU_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !m_axis_tvalid, "output valid in reset")

endmodule

bind bitmap_handle_allocator_unit bhau_checker u_bhau_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== dv/tb_top.sv =====
// Self-checking testbench for bitmap_handle_allocator_unit: a directed table, then random
// allocate and free traffic, with results checked against a predictor of the used-bit map.
// Depends on bhau_pkg and the bitmap_handle_allocator_unit RTL.
module tb_top;

    localparam int MAP_WORDS   = 16;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 40;

    // Result word as the predictor sees it.
    typedef struct packed {
        logic [bhau_pkg::HANDLE_W-1:0] handle;
        logic                          full;
    } alloc_res_t;

    // One row of the directed table; has_typed marks a hand-written expectation.
    typedef struct packed {
        logic                          op;
        logic [bhau_pkg::HANDLE_W-1:0] fh;
        logic                          has_typed;
        logic [bhau_pkg::HANDLE_W-1:0] typed_handle;
        logic                          typed_full;
    } dir_row_t;

    localparam int DIR_ROWS_N = 18;
    localparam dir_row_t DIR_ROWS [DIR_ROWS_N] = '{
        '{bhau_pkg::OP_ALLOC, 10'd0,    1'b1, 10'd0, 1'b0},
        '{bhau_pkg::OP_ALLOC, 10'd1023, 1'b1, 10'd1, 1'b0},
        '{bhau_pkg::OP_ALLOC, 10'd682,  1'b1, 10'd2, 1'b0},
        '{bhau_pkg::OP_FREE,  10'd1,    1'b0, 10'd0, 1'b0},
        '{bhau_pkg::OP_ALLOC, 10'd341,  1'b1, 10'd1, 1'b0},
        '{bhau_pkg::OP_FREE,  10'd1023, 1'b0, 10'd0, 1'b0},
        '{bhau_pkg::OP_FREE,  10'd0,    1'b0, 10'd0, 1'b0},
        '{bhau_pkg::OP_FREE,  10'd0,    1'b0, 10'd0, 1'b0},
        '{bhau_pkg::OP_ALLOC, 10'd0,    1'b1, 10'd0, 1'b0},
        '{bhau_pkg::OP_ALLOC, 10'd0,    1'b1, 10'd3, 1'b0},
        '{bhau_pkg::OP_FREE,  10'd682,  1'b0, 10'd0, 1'b0},
        '{bhau_pkg::OP_FREE,  10'd341,  1'b0, 10'd0, 1'b0},
        '{bhau_pkg::OP_FREE,  10'd64,   1'b0, 10'd0, 1'b0},
        '{bhau_pkg::OP_ALLOC, 10'd1023, 1'b1, 10'd4, 1'b0},
        '{bhau_pkg::OP_FREE,  10'd2,    1'b0, 10'd0, 1'b0},
        '{bhau_pkg::OP_ALLOC, 10'd0,    1'b1, 10'd2, 1'b0},
        '{bhau_pkg::OP_FREE,  10'd3,    1'b0, 10'd0, 1'b0},
        '{bhau_pkg::OP_ALLOC, 10'd512,  1'b0, 10'd0, 1'b0}
    };

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [bhau_pkg::TDATA_W-1:0]  s_axis_tdata = '0;
    logic                          s_axis_tuser = 1'b0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [bhau_pkg::TDATA_W-1:0]  m_axis_tdata;
    logic                          m_axis_tuser;

    // Predictor state: a copy of the used-bit map and the search hint.
    logic [63:0]         used_map [MAP_WORDS];
    int                  alloc_hint = 0;
    int                  full_predictions = 0;

    alloc_res_t          pending_allocs [$];
    int                  error_count = 0;
    int                  words_received = 0;
    int                  cycle_count = 0;
    int                  burst_left = 0;
    bit                  long_hold_done = 1'b0;

    bitmap_handle_allocator_unit #(
        .MAP_WORDS(MAP_WORDS)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    always #10 clk = ~clk;

    // Run limit in case the block hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("bitmap_handle_allocator_unit test failed");
            $finish;
        end
    end

    // Apply one request to the predicted map and work out its result, if any.
    task automatic apply_request(input logic op, input logic [bhau_pkg::HANDLE_W-1:0] fh,
                                 output bit gives_word, output alloc_res_t res);
        int  w;
        int  b;
        bit  found;
        res        = '0;
        gives_word = 1'b0;
        found      = 1'b0;
        if (op == bhau_pkg::OP_FREE)
        begin
            if ((fh >> 6) < MAP_WORDS)
                used_map[fh >> 6][fh[5:0]] = 1'b0;
        end
        else
        begin
            gives_word = 1'b1;
            if (alloc_hint >= MAP_WORDS)
                alloc_hint = 0;
            // Scan the words in rotation from the hint; first non-full word wins.
            for (int i = 0; i < MAP_WORDS; i++)
            begin
                w = (i + alloc_hint) % MAP_WORDS;
                if (!found && used_map[w] != '1)
                begin
                    b = 0;
                    while (used_map[w][b])
                        b++;
                    used_map[w][b] = 1'b1;
                    alloc_hint     = w;
                    res.handle     = bhau_pkg::HANDLE_W'(w * 64 + b);
                    found          = 1'b1;
                end
            end
            if (!found)
            begin
                res.full = 1'b1;
                full_predictions++;
            end
        end
    endtask

    // Offer one request word, wait for it to be taken, then record what it should return.
    task automatic send_request(input logic op, input logic [bhau_pkg::HANDLE_W-1:0] fh,
                                input bit use_typed, input alloc_res_t typed_res);
        bit         gives_word;
        alloc_res_t res;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {{(bhau_pkg::TDATA_W-bhau_pkg::HANDLE_W){1'b0}}, fh};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        apply_request(op, fh, gives_word, res);
        if (gives_word)
            pending_allocs.push_back(use_typed ? typed_res : res);
    endtask

    // Random gap between request words: mostly none or short, a few long, some bursts.
    task automatic sender_gap();
        int r;
        int n;
        r = $urandom_range(0, 99);
        n = 0;
        if (burst_left > 0)
            burst_left--;
        else if (r < 3)
            burst_left = 50;
        else if (r < 50)
            n = 0;
        else if (r < 90)
            n = $urandom_range(1, 3);
        else
            n = $urandom_range(10, 40);
        if (n > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // Mixed traffic; frees mostly land in the low handles where allocations live.
    task automatic random_traffic(input int count, input int alloc_pct, input int low_top);
        logic                          op;
        logic [bhau_pkg::HANDLE_W-1:0] fh;
        for (int k = 0; k < count; k++)
        begin
            op = ($urandom_range(0, 99) < alloc_pct) ? bhau_pkg::OP_ALLOC : bhau_pkg::OP_FREE;
            if ($urandom_range(0, 9) < 7)
                fh = bhau_pkg::HANDLE_W'($urandom_range(0, low_top));
            else
                fh = bhau_pkg::HANDLE_W'($urandom);
            send_request(op, fh, 1'b0, '0);
            sender_gap();
        end
    endtask

    task automatic wait_all_results();
        while (pending_allocs.size() != 0)
            @(posedge clk);
    endtask

    // Check each accepted result word against the oldest pending expectation.
    always @(posedge clk)
    begin
        alloc_res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            words_received <= words_received + 1;
            if (pending_allocs.size() == 0)
            begin
                $display("%0t: result word with nothing pending: handle %0d full %0b",
                         $time, m_axis_tdata[bhau_pkg::HANDLE_W-1:0], m_axis_tuser);
                error_count++;
            end
            else
            begin
                want = pending_allocs.pop_front();
                if (m_axis_tdata[bhau_pkg::HANDLE_W-1:0] !== want.handle)
                begin
                    $display("%0t: handle mismatch: expected %0d, actual %0d",
                             $time, want.handle, m_axis_tdata[bhau_pkg::HANDLE_W-1:0]);
                    error_count++;
                end
                if (m_axis_tuser !== want.full)
                begin
                    $display("%0t: full_res mismatch: expected %0b, actual %0b",
                             $time, want.full, m_axis_tuser);
                    error_count++;
                end
            end
        end
    end

    // Receiver: random ready pattern, with one long hold-off to back the block up.
    initial
    begin
        int hold;
        int r;
        hold = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!long_hold_done && words_received >= 40)
            begin
                long_hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (400) @(posedge clk);
                hold = 0;
            end
            else if (hold > 0)
                hold--;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                begin
                    m_axis_tready <= 1'b1;
                    hold = (r < 5) ? 100 : $urandom_range(0, 6);
                end
                else
                begin
                    m_axis_tready <= 1'b0;
                    hold = (r < 95) ? $urandom_range(1, 3) : $urandom_range(15, 50);
                end
            end
        end
    end

    // Main sequence: reset, directed table, random traffic, fill to full, more random traffic, drain.
    initial
    begin
        alloc_res_t typed_res;
        for (int i = 0; i < MAP_WORDS; i++)
            used_map[i] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table walk.
        for (int i = 0; i < DIR_ROWS_N; i++)
        begin
            typed_res.handle = DIR_ROWS[i].typed_handle;
            typed_res.full   = DIR_ROWS[i].typed_full;
            send_request(DIR_ROWS[i].op, DIR_ROWS[i].fh, DIR_ROWS[i].has_typed, typed_res);
            sender_gap();
        end

        random_traffic(120, 60, 255);

        // Pause until every result is back, then allocate until six allocations are predicted full.
        s_axis_tvalid <= 1'b0;
        wait_all_results();
        @(posedge clk);
        while (full_predictions < 6)
        begin
            send_request(bhau_pkg::OP_ALLOC, bhau_pkg::HANDLE_W'($urandom), 1'b0, '0);
            sender_gap();
        end

        // Frees across the whole handle range on a full map, mixed with allocations.
        random_traffic(100, 40, 1023);

        s_axis_tvalid <= 1'b0;
        wait_all_results();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (error_count == 0 && pending_allocs.size() == 0)
            $display("bitmap_handle_allocator_unit test passed");
        else
            $display("bitmap_handle_allocator_unit test failed");
        $finish;
    end
endmodule
